// ----- hdl/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared types and constants for the sorted timer queue and its cells.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int HANDLE_W      = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int POP_CNT_W     = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_ADJUST = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_SCAN,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_INS,
    S_RESP,
    S_POP
  } state_t;

  typedef struct packed {
    cell_op_t              op;
    logic [HANDLE_W-1:0]   key_handle;
  } cell_ctrl_t;

endpackage

// ----- hdl/stq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// Holds one timer and trades it with its neighbors on insert, remove and pop.
// ----------------------------------------------------------------------------
module stq_cell import stq_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctrl_t           ctrl,
  input  logic [TIME_BITS-1:0] key_time,
  input  logic [HANDLE_W-1:0]  left_handle,
  input  logic [TIME_BITS-1:0] left_time,
  input  logic                 left_valid,
  input  logic                 left_hit,
  input  logic                 left_gt,
  input  logic [HANDLE_W-1:0]  right_handle,
  input  logic [TIME_BITS-1:0] right_time,
  input  logic                 right_valid,
  output logic [HANDLE_W-1:0]  handle,
  output logic [TIME_BITS-1:0] expiry,
  output logic                 valid,
  output logic                 hit,
  output logic                 gt
);

  logic [HANDLE_W-1:0]  handle_r, handle_nxt;
  logic [TIME_BITS-1:0] expiry_r, expiry_nxt;
  logic                 valid_r, valid_nxt;
  logic                 hit_r, hit_nxt;

  // A cell is "greater" when it is empty or expires after the key time.
  assign gt     = !valid_r || (expiry_r > key_time);
  assign handle = handle_r;
  assign expiry = expiry_r;
  assign valid  = valid_r;
  assign hit    = hit_r;

  always_comb begin
    handle_nxt = handle_r;
    expiry_nxt = expiry_r;
    valid_nxt  = valid_r;
    hit_nxt    = hit_r;
    unique case (ctrl.op)
      CELL_HOLD: begin
      end
      CELL_CLEAR: begin
        hit_nxt = 1'b0;
      end
      CELL_SCAN: begin
        hit_nxt = left_hit || (valid_r && (handle_r == ctrl.key_handle));
      end
      CELL_INSERT: begin
        if (gt && left_gt) begin
          handle_nxt = left_handle;
          expiry_nxt = left_time;
          valid_nxt  = left_valid;
        end else if (gt) begin
          handle_nxt = ctrl.key_handle;
          expiry_nxt = key_time;
          valid_nxt  = 1'b1;
        end
      end
      CELL_REMOVE: begin
        if (hit_r) begin
          handle_nxt = right_handle;
          expiry_nxt = right_time;
          valid_nxt  = right_valid;
        end
      end
      CELL_POP: begin
        handle_nxt = right_handle;
        expiry_nxt = right_time;
        valid_nxt  = right_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    expiry_r <= expiry_nxt;
  end

endmodule

// ----- hdl/sorted_timer_queue.sv -----
// ----------------------------------------------------------------------------
// Sorted timer queue
// A row of cells keeping timers in ascending expiry order, with a sequencer.
// ----------------------------------------------------------------------------
// Timers sit in a row of CAPACITY cells, earliest first. Add, adjust and
// delete first walk a handle search down the row, one cell per cycle, then
// act on the row and give the result; adjust adds an insert step after the
// remove. A tick pops one due timer per cycle from the head while the output
// is free to take it. One item is worked on at a time; a result may wait in
// the output register while the next word is accepted.
module sorted_timer_queue import stq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // handle[15:0], expire_time[47:16], now_time[79:48]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status[2:0], expired_handle[18:3], zero[23:19]
  output logic        out_tlast
);

  localparam int CNT_W = $clog2(CAPACITY);

  state_t               state_r, state_nxt;
  kind_t                kind_r;
  logic [HANDLE_W-1:0]  handle_r;
  logic [TIME_BITS-1:0] exp_r;
  logic [TIME_BITS-1:0] now_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [POP_CNT_W-1:0] pop_cnt_r;
  status_t              status_r, status_nxt;

  logic                 out_tvalid_r;
  status_t              out_status_r;
  logic [HANDLE_W-1:0]  out_handle_r;
  logic                 out_last_r;

  logic                 out_load;
  status_t              out_status_nxt;
  logic [HANDLE_W-1:0]  out_handle_nxt;
  logic                 out_last_nxt;
  logic                 pop_inc;

  logic                 in_fire, out_free, found, full, due0, due1;
  cell_ctrl_t           ctrl;

  logic [HANDLE_W-1:0]  cell_handle [CAPACITY];
  logic [TIME_BITS-1:0] cell_exp    [CAPACITY];
  logic [CAPACITY-1:0]  cell_valid, cell_hit, cell_gt;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign found     = cell_hit[CAPACITY-1];
  assign full      = cell_valid[CAPACITY-1];
  assign due0      = cell_valid[0] && (cell_exp[0] <= now_r);
  assign due1      = cell_valid[1] && (cell_exp[1] <= now_r);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [HANDLE_W-1:0]  l_handle, r_handle;
    logic [TIME_BITS-1:0] l_time, r_time;
    logic                 l_valid, l_hit, l_gt, r_valid;
    if (i == 0) begin : g_first
      assign l_handle = '0;
      assign l_time   = '0;
      assign l_valid  = 1'b0;
      assign l_hit    = 1'b0;
      assign l_gt     = 1'b0;
    end else begin : g_mid
      assign l_handle = cell_handle[i-1];
      assign l_time   = cell_exp[i-1];
      assign l_valid  = cell_valid[i-1];
      assign l_hit    = cell_hit[i-1];
      assign l_gt     = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_handle = '0;
      assign r_time   = '0;
      assign r_valid  = 1'b0;
    end else begin : g_inner
      assign r_handle = cell_handle[i+1];
      assign r_time   = cell_exp[i+1];
      assign r_valid  = cell_valid[i+1];
    end
    stq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .key_time     (exp_r),
      .left_handle  (l_handle),
      .left_time    (l_time),
      .left_valid   (l_valid),
      .left_hit     (l_hit),
      .left_gt      (l_gt),
      .right_handle (r_handle),
      .right_time   (r_time),
      .right_valid  (r_valid),
      .handle       (cell_handle[i]),
      .expiry       (cell_exp[i]),
      .valid        (cell_valid[i]),
      .hit          (cell_hit[i]),
      .gt           (cell_gt[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (kind_t'(in_tuser) == KIND_TICK) ? S_POP : S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r == CNT_W'(CAPACITY - 1)) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = (kind_r == KIND_ADJUST && found) ? S_INS : S_RESP;
      end
      S_INS: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free && out_last_nxt) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.op         = CELL_HOLD;
    ctrl.key_handle = handle_r;
    status_nxt      = status_r;
    out_load        = 1'b0;
    out_status_nxt  = status_r;
    out_handle_nxt  = '0;
    out_last_nxt    = 1'b1;
    pop_inc         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ctrl.op = CELL_CLEAR;
      end
      S_SCAN: begin
        ctrl.op = CELL_SCAN;
      end
      S_EXEC: begin
        priority case (kind_r)
          KIND_ADD: begin
            if (found) begin
              status_nxt = ST_DUPLICATE;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              ctrl.op    = CELL_INSERT;
              status_nxt = ST_DONE;
            end
          end
          default: begin
            if (!found) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              ctrl.op    = CELL_REMOVE;
              status_nxt = ST_DONE;
            end
          end
        endcase
      end
      S_INS: begin
        ctrl.op    = CELL_INSERT;
        status_nxt = ST_DONE;
      end
      S_RESP: begin
        out_load = out_free;
      end
      S_POP: begin
        out_load = out_free;
        if (due0) begin
          out_status_nxt = ST_EXPIRED;
          out_handle_nxt = cell_handle[0];
          out_last_nxt   = (pop_cnt_r == POP_CNT_W'(MAX_RESULTS - 1)) || !due1;
          if (out_free) begin
            ctrl.op = CELL_POP;
            pop_inc = 1'b1;
          end
        end else begin
          out_status_nxt = ST_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
      pop_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
      if (in_fire) begin
        pop_cnt_r <= '0;
      end else if (pop_inc) begin
        pop_cnt_r <= pop_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (in_fire) begin
      kind_r   <= kind_t'(in_tuser);
      handle_r <= in_tdata[15:0];
      exp_r    <= TIME_BITS'(in_tdata[47:16]);
      now_r    <= TIME_BITS'(in_tdata[79:48]);
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_handle_r <= out_handle_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_handle_r, out_status_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid[CAPACITY-1:1] & ~cell_valid[CAPACITY-2:0]) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[1] |-> (cell_exp[0] <= cell_exp[1]))
    else $error("head cells out of expiry order");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == CELL_INSERT) |-> !cell_valid[CAPACITY-1])
    else $error("insert into a full row");

  a_pop_due: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == CELL_POP) |=> (out_tvalid && out_tdata[2:0] == ST_EXPIRED))
    else $error("pop without an expired result");
`endif

endmodule
